// ----- design/hamiltonian_cycle_search_assert.svh -----
// Assertion macros shared by the checker of this block.
`ifndef HAMILTONIAN_CYCLE_SEARCH_ASSERT_SVH
`define HAMILTONIAN_CYCLE_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HCS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hamiltonian_cycle_search: check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hamiltonian_cycle_search: check failed");

`endif

// ----- design/hcs_pkg.sv -----
`default_nettype none
package hcs_pkg;
	localparam int NODE_W = 5;
	localparam int STATUS_W = 2;
	localparam int DEF_MAX_NODES = 20;
	localparam int DEF_MAX_DEGREE = 32;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_RUN = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;
endpackage
`default_nettype wire

// ----- design/hamiltonian_cycle_search.sv -----
// Hamiltonian cycle search. Edges are written as requests with cmd low; an edge whose
// endpoints are both in range is written one endpoint at a time, because the neighbor
// table has a single write port. A request with cmd high runs a depth-first backtracking
// search over start nodes 1 to node_count, capped at MAX_NODES. Its time depends on the
// graph: each neighbor tried takes a table read, then an evaluation, each step back
// undoes one node, and each start node is set up, then searched until exhausted. The result
// then leaves at one item per cycle while out_stall is low: node_count path items (capped
// likewise), or one item with status 0 when no cycle exists. No new request is taken
// until the last result item of a run has been taken. Neighbor lists are emptied after
// each run.
`default_nettype none
module hamiltonian_cycle_search #(
	parameter int MAX_NODES = hcs_pkg::DEF_MAX_NODES,
	parameter int MAX_DEGREE = hcs_pkg::DEF_MAX_DEGREE
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [hcs_pkg::NODE_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic cmd,
	input wire logic [hcs_pkg::NODE_W-1:0] edge_from,
	input wire logic [hcs_pkg::NODE_W-1:0] edge_to,
	output logic out_valid,
	input wire logic out_stall,
	output logic [hcs_pkg::STATUS_W-1:0] status,
	output logic [hcs_pkg::NODE_W-1:0] path_position,
	output logic [hcs_pkg::NODE_W-1:0] path_node,
	output logic last
);
	import hcs_pkg::*;

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DW = $clog2(MAX_NODES + 1);
	localparam int CW = $clog2(MAX_DEGREE + 1);
	localparam int DEPTH = MAX_NODES * MAX_DEGREE;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADD_B = 6'b000010,
		S_INIT = 6'b000100,
		S_STEP = 6'b001000,
		S_EVAL = 6'b010000,
		S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [NODE_W-1:0] node_count_q;
	logic [NODE_W-1:0] edge_b_q;
	logic [NODE_W-1:0] edge_a_q;
	logic [CW-1:0] count_q [MAX_NODES];
	logic [MAX_NODES-1:0] visited_q;
	logic [NODE_W-1:0] path_q [MAX_NODES];
	logic [CW-1:0] cursor_q [MAX_NODES];
	logic [DW-1:0] depth_q;
	logic [NODE_W-1:0] start_q;
	logic dropped_q;
	logic [NODE_W-1:0] table_mem [DEPTH];
	logic [NODE_W-1:0] rdata_q;

	logic out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [NODE_W-1:0] pos_q;
	logic [NODE_W-1:0] node_q;
	logic last_q;

	logic [NODE_W-1:0] n_eff;
	logic [IW-1:0] top_idx;
	logic [IW-1:0] prev_idx;
	logic [IW-1:0] next_idx;
	logic [NODE_W-1:0] cur;
	logic [IW-1:0] cur_row;
	logic [CW-1:0] cur_cursor;
	logic [IW-1:0] v_idx;
	logic [IW-1:0] a_row;
	logic [IW-1:0] b_row;
	logic a_full;
	logic b_full;
	logic edge_bad;
	logic in_take;
	logic out_take;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [NODE_W-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [IW-1:0] next_pos_idx;

	always_comb begin
		n_eff = (node_count_q > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_q;
		top_idx = IW'(depth_q - DW'(1));
		prev_idx = IW'(depth_q - DW'(2));
		next_idx = IW'(depth_q);
		cur = path_q[top_idx];
		cur_row = IW'(cur - NODE_W'(1));
		cur_cursor = cursor_q[top_idx];
		v_idx = IW'(rdata_q - NODE_W'(1));
		a_row = IW'(edge_from - NODE_W'(1));
		b_row = IW'(edge_b_q - NODE_W'(1));
		a_full = (count_q[a_row] >= CW'(MAX_DEGREE));
		b_full = (count_q[b_row] >= CW'(MAX_DEGREE));
		edge_bad = (edge_from == '0) || (edge_to == '0) || (edge_from > n_eff) ||
			(edge_to > n_eff);
		in_take = in_valid && (state_q == S_IDLE);
		out_take = out_valid_q && !out_stall;
		next_pos_idx = IW'(pos_q + NODE_W'(1));
		mem_raddr = AW'(AW'(cur_row) * AW'(MAX_DEGREE) + AW'(cur_cursor));
		// One write port: the first endpoint is written in the request cycle,
		// the second one in the following cycle.
		mem_we = 1'b0;
		mem_waddr = AW'(AW'(a_row) * AW'(MAX_DEGREE) + AW'(count_q[a_row]));
		mem_wdata = edge_to;
		if (in_take && cmd == CMD_EDGE && !edge_bad && !a_full) begin
			mem_we = 1'b1;
		end else if (state_q == S_ADD_B) begin
			mem_we = !b_full;
			mem_waddr = AW'(AW'(b_row) * AW'(MAX_DEGREE) + AW'(count_q[b_row]));
			mem_wdata = edge_a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_STEP) begin
			rdata_q <= table_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			node_count_q <= NODE_W'(1);
			for (int i = 0; i < MAX_NODES; i++) begin
				count_q[i] <= '0;
			end
			visited_q <= '0;
			depth_q <= '0;
			start_q <= NODE_W'(1);
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				node_count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (cmd == CMD_EDGE) begin
							if (edge_bad) begin
								dropped_q <= 1'b1;
							end else begin
								if (a_full) begin
									dropped_q <= 1'b1;
								end else begin
									count_q[a_row] <= count_q[a_row] + CW'(1);
								end
								edge_a_q <= edge_from;
								edge_b_q <= edge_to;
								state_q <= S_ADD_B;
							end
						end else begin
							start_q <= NODE_W'(1);
							if (n_eff == '0) begin
								status_q <= STATUS_NONE;
								pos_q <= '0;
								node_q <= '0;
								last_q <= 1'b1;
								out_valid_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_INIT;
							end
						end
					end
				end
				S_ADD_B: begin
					if (b_full) begin
						dropped_q <= 1'b1;
					end else begin
						count_q[b_row] <= count_q[b_row] + CW'(1);
					end
					state_q <= S_IDLE;
				end
				S_INIT: begin
					visited_q <= '0;
					visited_q[IW'(start_q - NODE_W'(1))] <= 1'b1;
					path_q[0] <= start_q;
					cursor_q[0] <= '0;
					depth_q <= DW'(1);
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (cur_cursor >= count_q[cur_row]) begin
						if (depth_q == DW'(1)) begin
							// Every branch from this start node is exhausted.
							if (start_q == n_eff) begin
								status_q <= STATUS_NONE;
								pos_q <= '0;
								node_q <= '0;
								last_q <= 1'b1;
								out_valid_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								start_q <= start_q + NODE_W'(1);
								state_q <= S_INIT;
							end
						end else begin
							depth_q <= depth_q - DW'(1);
							visited_q[cur_row] <= 1'b0;
							cursor_q[prev_idx] <= cursor_q[prev_idx] + CW'(1);
						end
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_STEP;
					if (rdata_q == '0 || rdata_q > n_eff) begin
						cursor_q[top_idx] <= cur_cursor + CW'(1);
					end else if (!visited_q[v_idx]) begin
						path_q[next_idx] <= rdata_q;
						visited_q[v_idx] <= 1'b1;
						depth_q <= depth_q + DW'(1);
						cursor_q[next_idx] <= '0;
					end else if (rdata_q == start_q && NODE_W'(depth_q) == n_eff) begin
						status_q <= dropped_q ? STATUS_DROPPED : STATUS_FOUND;
						pos_q <= '0;
						node_q <= path_q[0];
						last_q <= (n_eff == NODE_W'(1));
						out_valid_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						cursor_q[top_idx] <= cur_cursor + CW'(1);
					end
				end
				S_OUT: begin
					if (out_take) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							for (int i = 0; i < MAX_NODES; i++) begin
								count_q[i] <= '0;
							end
							dropped_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_q + NODE_W'(1);
							node_q <= path_q[next_pos_idx];
							last_q <= (pos_q + NODE_W'(2) == n_eff);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign path_position = pos_q;
	assign path_node = node_q;
	assign last = last_q;
endmodule
`default_nettype wire

// ----- design/hcs_checker.sv -----
`default_nettype none
`include "hamiltonian_cycle_search_assert.svh"
module hcs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [hcs_pkg::STATUS_W-1:0] status,
	input wire logic [hcs_pkg::NODE_W-1:0] path_position,
	input wire logic [hcs_pkg::NODE_W-1:0] path_node,
	input wire logic last
);
	import hcs_pkg::*;

	// A stalled result holds still.
	`HCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(path_node) && $stable(path_position) && $stable(last))
	// A run without a cycle reports exactly one empty item.
	`HCS_ASSERT_SAME(a_none_item, out_valid && status == STATUS_NONE, last && path_node == '0 && path_position == '0)
	// A cycle never contains node zero.
	`HCS_ASSERT_SAME(a_found_node, out_valid && status != STATUS_NONE, path_node != '0)
	// Path items of one run follow each other with rising positions.
	`HCS_ASSERT_NEXT(a_pos_step, out_valid && !out_stall && !last, out_valid && path_position == $past(path_position) + 5'd1)
	// Only the three defined status codes appear.
	`HCS_ASSERT_SAME(a_status_code, out_valid, status == STATUS_NONE || status == STATUS_FOUND || status == STATUS_DROPPED)
endmodule

bind hamiltonian_cycle_search hcs_checker u_hcs_checker (.*);
`default_nettype wire
